// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define CHECK_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("design check failed");

// When the antecedent holds, the consequent must hold in the cycle after.
`define CHECK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("design check failed");

`endif

// File: rtl/core/gtgc_pkg.sv
package gtgc_pkg;

   localparam int LAT_W   = 31;
   localparam int LON_W   = 32;
   localparam int CELL_W  = 17;
   localparam int GRID_W  = 11;
   localparam int IDX_W   = 11;
   localparam int PROD_W  = 62;
   localparam int DIVR_W  = 41;
   localparam int SCALE_W = 28;

   localparam int DEF_MAX_ROWS = 1024;
   localparam int DEF_MAX_COLS = 1024;

   localparam logic signed [31:0] Q30_ONE  = 32'sd1073741824;
   localparam logic [31:0]        ANGLE_K  = 32'd4024455254;
   localparam logic [31:0]        QUARTER_TURN = 32'd1800000000;
   localparam logic [31:0]        HALF_TURN    = 32'd3600000000;

   localparam logic [26:0] MM_A      = 27'd111132954;
   localparam logic [19:0] MM_B      = 20'd559822;
   localparam logic [10:0] MM_C      = 11'd1175;
   localparam logic [23:0] DEG_UNITS = 24'd10000000;

   // Horner divisors (2k-1)*2k for k from 11 down to 1.
   localparam int HORNER_STEPS = 11;
   localparam logic [8:0] HORNER_M [HORNER_STEPS] = '{
      9'd462, 9'd380, 9'd306, 9'd240, 9'd182, 9'd132,
      9'd90, 9'd56, 9'd30, 9'd12, 9'd2
   };

   typedef enum logic [2:0] {
      REG_ORIGIN_LAT = 3'd0,
      REG_ORIGIN_LON = 3'd1,
      REG_CELL_SIZE  = 3'd2,
      REG_GRID_ROWS  = 3'd3,
      REG_GRID_COLS  = 3'd4
   } reg_idx_type;

   typedef struct packed {
      logic signed [31:0] dlat;
      logic signed [32:0] dlon;
   } offs_type;

   typedef struct packed {
      logic               neg;
      logic signed [31:0] t;
      offs_type           offs;
   } cos_res_type;

endpackage

// File: rtl/core/gtgc_cos.sv
module gtgc_cos
   import gtgc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  logic signed [LAT_W-1:0] point_lat,
   input  logic signed [LON_W-1:0] point_lon,
   input  logic signed [LAT_W-1:0] origin_lat,
   input  logic signed [LON_W-1:0] origin_lon,
   output logic                    out_valid,
   output cos_res_type             out_res
);

   typedef struct packed {
      logic [31:0] y;
      logic        neg;
      offs_type    offs;
   } carry_type;

   // Front: angle magnitude, reflection past a quarter turn, offsets.
   logic signed [31:0] sum_in;
   logic [31:0]        mag_in;
   logic               reflect_in;
   logic [30:0]        a_in;
   offs_type           offs_in;

   logic        v0_ff, v1_ff, v2_ff;
   logic [30:0] a_ff;
   logic [30:0] x_ff;
   logic [31:0] y_ff;
   logic        neg0_ff, neg1_ff, neg2_ff;
   offs_type    offs0_ff, offs1_ff, offs2_ff;

   logic [62:0] xk_prod;
   logic [61:0] xx_prod;

   assign sum_in     = 32'(point_lat) + 32'(origin_lat);
   assign mag_in     = sum_in[31] ? 32'(-sum_in) : 32'(sum_in);
   assign reflect_in = mag_in > QUARTER_TURN;
   assign a_in       = reflect_in ? 31'(HALF_TURN - mag_in) : 31'(mag_in);
   assign offs_in.dlat = 32'(point_lat) - 32'(origin_lat);
   assign offs_in.dlon = 33'(point_lon) - 33'(origin_lon);

   assign xk_prod = 63'(a_ff) * 63'(ANGLE_K);
   assign xx_prod = 62'(x_ff) * 62'(x_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
      if (advance) begin
         a_ff     <= a_in;
         neg0_ff  <= reflect_in;
         offs0_ff <= offs_in;
         x_ff     <= xk_prod[62:32];
         neg1_ff  <= neg0_ff;
         offs1_ff <= offs0_ff;
         y_ff     <= xx_prod[61:30];
         neg2_ff  <= neg1_ff;
         offs2_ff <= offs1_ff;
      end
   end

   // Horner steps: each is multiply, reciprocal multiply, then correction.
   logic               va_ff [HORNER_STEPS];
   logic               vb_ff [HORNER_STEPS];
   logic               vc_ff [HORNER_STEPS];
   carry_type          ca_ff [HORNER_STEPS];
   carry_type          cb_ff [HORNER_STEPS];
   carry_type          cc_ff [HORNER_STEPS];
   logic [31:0]        pa_ff [HORNER_STEPS];
   logic [31:0]        pb_ff [HORNER_STEPS];
   logic               sa_ff [HORNER_STEPS];
   logic               sb_ff [HORNER_STEPS];
   logic [31:0]        q0_ff [HORNER_STEPS];
   logic signed [31:0] t_ff  [HORNER_STEPS];

   for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_step
      localparam logic [8:0]  M = HORNER_M[i];
      localparam int          S = 31 + $clog2(M);
      localparam logic [31:0] R = 32'((64'd1 << S) / M);

      logic               valid_prev;
      carry_type          carry_prev;
      logic signed [31:0] t_prev;
      logic [30:0]        t_mag;
      logic [62:0]        p;
      logic [63:0]        qm;
      logic [41:0]        back;
      logic [41:0]        rem;
      logic [31:0]        q;
      logic signed [31:0] t_in;

      if (i == 0) begin : g_head
         assign valid_prev = v2_ff;
         assign carry_prev = '{y: y_ff, neg: neg2_ff, offs: offs2_ff};
         assign t_prev     = Q30_ONE;
      end else begin : g_link
         assign valid_prev = vc_ff[i-1];
         assign carry_prev = cc_ff[i-1];
         assign t_prev     = t_ff[i-1];
      end

      assign t_mag = t_prev[31] ? 31'(-t_prev) : 31'(t_prev);
      assign p     = 63'(carry_prev.y) * 63'(t_mag);
      assign qm    = 64'(pa_ff[i]) * 64'(R);
      assign back  = 42'(q0_ff[i]) * 42'(M);
      assign rem   = 42'(pb_ff[i]) - back;
      // The reciprocal estimate is at most one short of the true quotient.
      assign q     = q0_ff[i] + 32'(rem >= 42'(M));
      assign t_in  = Q30_ONE - (sb_ff[i] ? -$signed(q) : $signed(q));

      always_ff @(posedge clock) begin
         if (reset) begin
            va_ff[i] <= 1'b0;
            vb_ff[i] <= 1'b0;
            vc_ff[i] <= 1'b0;
         end else if (advance) begin
            va_ff[i] <= valid_prev;
            vb_ff[i] <= va_ff[i];
            vc_ff[i] <= vb_ff[i];
         end
         if (advance) begin
            pa_ff[i] <= p[61:30];
            sa_ff[i] <= t_prev[31];
            ca_ff[i] <= carry_prev;
            q0_ff[i] <= 32'(qm >> S);
            pb_ff[i] <= pa_ff[i];
            sb_ff[i] <= sa_ff[i];
            cb_ff[i] <= ca_ff[i];
            t_ff[i]  <= t_in;
            cc_ff[i] <= cb_ff[i];
         end
      end
   end

   assign out_valid     = vc_ff[HORNER_STEPS-1];
   assign out_res.neg   = cc_ff[HORNER_STEPS-1].neg;
   assign out_res.t     = t_ff[HORNER_STEPS-1];
   assign out_res.offs  = cc_ff[HORNER_STEPS-1].offs;

endmodule

// File: rtl/core/gtgc_scale.sv
module gtgc_scale
   import gtgc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  cos_res_type              in_res,
   output logic                     out_valid,
   output logic signed [PROD_W-1:0] north,
   output logic signed [PROD_W-1:0] east
);

   // Stage 0: sign of cos(x), its square and the longitude product.
   logic signed [31:0] c1_in;
   logic [30:0]        abs1_in;
   logic [61:0]        sq1_in;
   logic signed [59:0] lonp_in;

   logic               v0_ff;
   logic [61:0]        sq1_ff;
   logic signed [59:0] lonp_ff;
   offs_type           offs0_ff;

   assign c1_in   = in_res.neg ? -in_res.t : in_res.t;
   assign abs1_in = in_res.t[31] ? 31'(-in_res.t) : 31'(in_res.t);
   assign sq1_in  = 62'(abs1_in) * 62'(abs1_in);
   assign lonp_in = 60'($signed({1'b0, MM_A})) * 60'(c1_in);

   // Stage 1: cos(2x), its square, the cos(2x) term and the lon scale.
   logic signed [31:0]        c2_in;
   logic [30:0]               abs2_in;
   logic [61:0]               sq2_in;
   logic signed [52:0]        bc2_in;
   logic signed [SCALE_W-1:0] lon_scale_in;

   logic                      v1_ff;
   logic [61:0]               sq2_ff;
   logic signed [52:0]        bc2_ff;
   logic signed [SCALE_W-1:0] lon1_ff;
   offs_type                  offs1_ff;

   assign c2_in        = $signed(sq1_ff[60:29]) - Q30_ONE;
   assign abs2_in      = c2_in[31] ? 31'(-c2_in) : 31'(c2_in);
   assign sq2_in       = 62'(abs2_in) * 62'(abs2_in);
   assign bc2_in       = 53'($signed({1'b0, MM_B})) * 53'(c2_in);
   assign lon_scale_in = SCALE_W'((lonp_ff + 60'sd536870912) >>> 30);

   // Stage 2: cos(4x) term.
   logic signed [31:0]        c4_in;
   logic signed [43:0]        cc4_in;

   logic                      v2_ff;
   logic signed [52:0]        bc2_2_ff;
   logic signed [43:0]        cc4_ff;
   logic signed [SCALE_W-1:0] lon2_ff;
   offs_type                  offs2_ff;

   assign c4_in  = $signed(sq2_ff[60:29]) - Q30_ONE;
   assign cc4_in = 44'($signed({1'b0, MM_C})) * 44'(c4_in);

   // Stage 3: rounded latitude scale.
   logic signed [55:0]        lat_sum;
   logic signed [SCALE_W-1:0] lat_scale_in;

   logic                      v3_ff;
   logic signed [SCALE_W-1:0] lat3_ff;
   logic signed [SCALE_W-1:0] lon3_ff;
   offs_type                  offs3_ff;

   assign lat_sum      = 56'(cc4_ff) - 56'(bc2_2_ff) + 56'sd536870912;
   assign lat_scale_in = SCALE_W'(56'($signed({1'b0, MM_A})) + (lat_sum >>> 30));

   // Stage 4: offsets in units of 1e-7 mm.
   logic signed [PROD_W-1:0] north_in;
   logic signed [PROD_W-1:0] east_in;
   logic                     v4_ff;

   assign north_in = PROD_W'(offs3_ff.dlat) * PROD_W'(lat3_ff);
   assign east_in  = PROD_W'(offs3_ff.dlon) * PROD_W'(lon3_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      if (advance) begin
         sq1_ff   <= sq1_in;
         lonp_ff  <= lonp_in;
         offs0_ff <= in_res.offs;
         sq2_ff   <= sq2_in;
         bc2_ff   <= bc2_in;
         lon1_ff  <= lon_scale_in;
         offs1_ff <= offs0_ff;
         bc2_2_ff <= bc2_ff;
         cc4_ff   <= cc4_in;
         lon2_ff  <= lon1_ff;
         offs2_ff <= offs1_ff;
         lat3_ff  <= lat_scale_in;
         lon3_ff  <= lon2_ff;
         offs3_ff <= offs2_ff;
         north    <= north_in;
         east     <= east_in;
      end
   end

   assign out_valid = v4_ff;

endmodule

// File: rtl/core/gtgc_div.sv
module gtgc_div
   import gtgc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  logic signed [PROD_W-1:0] value,
   input  logic [DIVR_W-1:0]        divisor,
   input  logic [IDX_W-1:0]         lim,
   output logic                     out_valid,
   output logic                     out_ok,
   output logic [IDX_W-1:0]         out_q
);

   localparam int REM_W = DIVR_W + IDX_W;

   // Entry: a negative offset, a zero divisor or a quotient too large for the
   // index width marks the transaction as outside.
   logic              over_in;
   logic              bad_in;
   logic              v0_ff;
   logic              bad0_ff;
   logic [REM_W-1:0]  rem0_ff;

   assign over_in = value[PROD_W-2:0] >= (PROD_W-1)'({divisor, {IDX_W{1'b0}}});
   assign bad_in  = value[PROD_W-1] | (divisor == '0) | over_in;

   // One quotient bit per stage, most significant first.
   logic             sv_ff   [IDX_W];
   logic             sbad_ff [IDX_W];
   logic [REM_W-1:0] srem_ff [IDX_W];
   logic [IDX_W-1:0] sq_ff   [IDX_W];

   for (genvar j = 0; j < IDX_W; j++) begin : g_bit
      localparam int B = IDX_W - 1 - j;

      logic             valid_prev;
      logic             bad_prev;
      logic [REM_W-1:0] rem_prev;
      logic [IDX_W-1:0] q_prev;
      logic [REM_W-1:0] trial;
      logic             take;

      if (j == 0) begin : g_head
         assign valid_prev = v0_ff;
         assign bad_prev   = bad0_ff;
         assign rem_prev   = rem0_ff;
         assign q_prev     = '0;
      end else begin : g_link
         assign valid_prev = sv_ff[j-1];
         assign bad_prev   = sbad_ff[j-1];
         assign rem_prev   = srem_ff[j-1];
         assign q_prev     = sq_ff[j-1];
      end

      assign trial = REM_W'(divisor) << B;
      assign take  = rem_prev >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[j] <= 1'b0;
         end else if (advance) begin
            sv_ff[j] <= valid_prev;
         end
         if (advance) begin
            sbad_ff[j] <= bad_prev;
            srem_ff[j] <= take ? rem_prev - trial : rem_prev;
            sq_ff[j]   <= q_prev | (IDX_W'(take) << B);
         end
      end
   end

   logic             vout_ff;
   logic             ok_ff;
   logic [IDX_W-1:0] q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff   <= 1'b0;
         vout_ff <= 1'b0;
      end else if (advance) begin
         v0_ff   <= in_valid;
         vout_ff <= sv_ff[IDX_W-1];
      end
      if (advance) begin
         bad0_ff <= bad_in;
         rem0_ff <= value[REM_W-1:0];
         ok_ff   <= !sbad_ff[IDX_W-1] && (sq_ff[IDX_W-1] < lim);
         q_ff    <= sq_ff[IDX_W-1];
      end
   end

   assign out_valid = vout_ff;
   assign out_ok    = ok_ff;
   assign out_q     = q_ff;

endmodule

// File: rtl/core/gps_to_grid_cell.sv
// Path: a fix accepted on req passes the cos, scale and divider pipelines
// and then the result buffer before it shows on rsp.
// Throughput: one fix per cycle; the 54-stage pipeline stalls as a whole only
// while the two-entry result buffer is full.
// Reset: synchronous, active high; clears valid bits and the result buffer and
// loads the register defaults (origin 0, cell 1000 mm, 64 by 64 grid).
`include "assert_macros.svh"

module gps_to_grid_cell
   import gtgc_pkg::*;
#(
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   parameter int MAX_COLS = DEF_MAX_COLS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [30:0] point_lat, [62:31] point_lon
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [10:0] row_index, [21:11] col_index
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // Register file.
   logic signed [LAT_W-1:0] origin_lat_ff;
   logic signed [LON_W-1:0] origin_lon_ff;
   logic [CELL_W-1:0]       cell_size_ff;
   logic [GRID_W-1:0]       grid_rows_ff;
   logic [GRID_W-1:0]       grid_cols_ff;
   logic                    csr_write;
   reg_idx_type             csr_idx;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = reg_idx_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_lat_ff <= '0;
         origin_lon_ff <= '0;
         cell_size_ff  <= CELL_W'(1000);
         grid_rows_ff  <= GRID_W'(64);
         grid_cols_ff  <= GRID_W'(64);
      end else if (csr_write) begin
         unique case (csr_idx)
            REG_ORIGIN_LAT: origin_lat_ff <= csr_pwdata[LAT_W-1:0];
            REG_ORIGIN_LON: origin_lon_ff <= csr_pwdata[LON_W-1:0];
            REG_CELL_SIZE:  cell_size_ff  <= csr_pwdata[CELL_W-1:0];
            REG_GRID_ROWS:  grid_rows_ff  <= csr_pwdata[GRID_W-1:0];
            REG_GRID_COLS:  grid_cols_ff  <= csr_pwdata[GRID_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_ORIGIN_LAT: csr_prdata = 32'({1'b0, origin_lat_ff});
         REG_ORIGIN_LON: csr_prdata = origin_lon_ff;
         REG_CELL_SIZE:  csr_prdata = 32'(cell_size_ff);
         REG_GRID_ROWS:  csr_prdata = 32'(grid_rows_ff);
         REG_GRID_COLS:  csr_prdata = 32'(grid_cols_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // Static terms derived from the registers.
   logic [DIVR_W-1:0] divisor_ff;
   logic [IDX_W-1:0]  row_lim;
   logic [IDX_W-1:0]  col_lim;

   always_ff @(posedge clock) begin
      divisor_ff <= DIVR_W'(cell_size_ff) * DIVR_W'(DEG_UNITS);
   end

   assign row_lim = (32'(grid_rows_ff) < MAX_ROWS) ? grid_rows_ff : IDX_W'(MAX_ROWS);
   assign col_lim = (32'(grid_cols_ff) < MAX_COLS) ? grid_cols_ff : IDX_W'(MAX_COLS);

   // Pipeline.
   logic                     advance;
   logic                     cos_valid;
   cos_res_type              cos_res;
   logic                     scl_valid;
   logic signed [PROD_W-1:0] north;
   logic signed [PROD_W-1:0] east;
   logic                     row_valid;
   logic                     row_ok;
   logic [IDX_W-1:0]         row_q;
   logic                     col_valid;
   logic                     col_ok;
   logic [IDX_W-1:0]         col_q;

   assign req_tready = advance;

   gtgc_cos u_cos (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_tvalid),
      .point_lat  (req_tdata[30:0]),
      .point_lon  (req_tdata[62:31]),
      .origin_lat (origin_lat_ff),
      .origin_lon (origin_lon_ff),
      .out_valid  (cos_valid),
      .out_res    (cos_res)
   );

   gtgc_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (cos_valid),
      .in_res    (cos_res),
      .out_valid (scl_valid),
      .north     (north),
      .east      (east)
   );

   gtgc_div u_row_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (scl_valid),
      .value     (north),
      .divisor   (divisor_ff),
      .lim       (row_lim),
      .out_valid (row_valid),
      .out_ok    (row_ok),
      .out_q     (row_q)
   );

   gtgc_div u_col_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (scl_valid),
      .value     (east),
      .divisor   (divisor_ff),
      .lim       (col_lim),
      .out_valid (col_valid),
      .out_ok    (col_ok),
      .out_q     (col_q)
   );

   // Two-entry result buffer; the pipeline moves while it has room.
   logic                   cell_in;
   logic [2*IDX_W-1:0]     result_in;
   logic                   push;
   logic                   pop;
   logic [2*IDX_W-1:0]     fifo_ff [2];
   logic                   wr_ptr_ff;
   logic                   rd_ptr_ff;
   logic [1:0]             fifo_count_ff;

   assign cell_in   = row_ok & col_ok;
   assign result_in = cell_in ? {col_q, row_q} : '1;
   assign advance   = fifo_count_ff != 2'd2;
   assign push      = row_valid & col_valid & advance;
   assign pop       = rsp_tvalid & rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= 1'b0;
         rd_ptr_ff     <= 1'b0;
         fifo_count_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         fifo_count_ff <= fifo_count_ff + 2'(push) - 2'(pop);
      end
      if (push) begin
         fifo_ff[wr_ptr_ff] <= result_in;
      end
   end

   assign rsp_tvalid = fifo_count_ff != 2'd0;
   assign rsp_tdata  = {2'b00, fifo_ff[rd_ptr_ff]};

   `CHECK_ALWAYS(a_both_or_neither, clock, reset,
      !rsp_tvalid || ((rsp_tdata[10:0] == '1) == (rsp_tdata[21:11] == '1)))
   `CHECK_NEXT(a_stall_keeps_result, clock, reset,
      row_valid && !advance, row_valid && col_valid)
   `CHECK_ALWAYS(a_buffer_bound, clock, reset, fifo_count_ff != 2'd3)

endmodule
